/* rtl/core/multi_stack_shared_free_list_unit_defines.svh */
// Assertion macros for the multi-stack shared free list unit.
// Each macro checks a property on the rising edge of i_clk, with reset held off.
`ifndef MULTI_STACK_SHARED_FREE_LIST_UNIT_DEFINES_SVH
`define MULTI_STACK_SHARED_FREE_LIST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSFL_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
`define MSFL_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define MSFL_ASSERT_SAME(label, cond, cons, msg)
`define MSFL_ASSERT_NEXT(label, cond, cons, msg)
`endif
`endif

/* rtl/core/msfl_pkg.sv */
package msfl_pkg;

    localparam int DEPTH  = 16;
    localparam int STACKS = 3;

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int SID_W  = 2;
    localparam int MASK_W = 3;
    localparam int MASK_N = (STACKS < MASK_W) ? STACKS : MASK_W;

    typedef logic [PTR_W-1:0] t_ptr;

    // null link: one past the last slot
    localparam t_ptr LINK_NULL = PTR_W'(DEPTH);

    localparam logic signed [DATA_W-1:0] EMPTY_POP_VALUE = 32'sh7FFF_FFFF;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        operation;
        logic [SID_W-1:0]           stack_id;
        logic signed [DATA_W-1:0]   push_value;
    } t_msfl_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]   popped_value;
        t_status                    status;
        logic                       store_full;
        logic [MASK_W-1:0]          empty_mask;
    } t_msfl_out;

    function automatic logic ptr_ok(input t_ptr p);
        return p < LINK_NULL;
    endfunction

endpackage

/* rtl/core/msfl_ram.sv */
module msfl_ram #(
    parameter int DATA_W  = 32,
    parameter int DEPTH_P = 16,
    parameter int ADDR_W  = $clog2(DEPTH_P)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH_P];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/multi_stack_shared_free_list_unit.sv */
// Multi-stack shared free list unit.
// Several LIFO stacks share one store of DEPTH slots. Each slot holds a data
// word (data RAM) and a link to the slot below it (link RAM); free slots are
// chained on one shared free list headed by a register.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; i_in carries operation, stack_id and push_value.
// Result channel: o_strobe marks the single cycle in which o_out holds the
// result (popped value, status, store_full, empty_mask). The receiver cannot
// stall; it must take the result in that cycle.
// Timing: the accepting edge registers the command and reads the link and data
// RAMs; the execute state writes them back, updates the stack tops and free
// head and registers the result. busy stays high through the execute state,
// so a new command is only taken once the current one is done.
// Reset: stack tops go null and the free head goes to slot zero. A clearing
// pass then walks the link RAM, one slot a cycle, over all DEPTH slots,
// chaining slot i to slot i+1; busy is high throughout and no command is taken.
// The data RAM is not cleared; a pop only returns a slot that a push wrote.
`include "multi_stack_shared_free_list_unit_defines.svh"

module multi_stack_shared_free_list_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  msfl_pkg::t_msfl_in  i_in,
    output logic                busy,
    output logic                o_strobe,
    output msfl_pkg::t_msfl_out o_out
);
    import msfl_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state    r_state,    n_state;
    t_ptr      r_init_cnt, n_init_cnt;
    t_ptr      r_free,     n_free;
    t_ptr      r_top [STACKS];
    t_ptr      n_top [STACKS];
    t_op       r_op,       n_op;
    logic [SID_W-1:0] r_sid, n_sid;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic      r_exists,   n_exists;
    t_ptr      r_top_sel,  n_top_sel;
    logic      r_strobe,   n_strobe;
    t_msfl_out r_out,      n_out;

    // command decode at the accepting edge
    t_ptr              top_sel;
    logic              exists;
    t_ptr              rd_ptr;
    logic [ADDR_W-1:0] rd_addr;

    // RAM ports
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    t_ptr              link_wdata;
    t_ptr              link_rdata;
    logic              data_we;
    logic [ADDR_W-1:0] data_waddr;
    logic [DATA_W-1:0] data_wdata;
    logic [DATA_W-1:0] data_rdata;

    msfl_ram #(
        .DATA_W  (PTR_W),
        .DEPTH_P (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    msfl_ram #(
        .DATA_W  (DATA_W),
        .DEPTH_P (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (rd_addr),
        .o_rdata (data_rdata)
    );

    // select the addressed stack top; a stack that does not exist reads null
    always_comb begin
        top_sel = LINK_NULL;
        exists  = 1'b0;
        for (int s = 0; s < STACKS; s++) begin
            if (int'(i_in.stack_id) == s) begin
                top_sel = r_top[s];
                exists  = 1'b1;
            end
        end
    end

    // push reads the free head, pop reads the stack top; drive zero for null
    assign rd_ptr  = (i_in.operation == OP_POP) ? top_sel : r_free;
    assign rd_addr = ptr_ok(rd_ptr) ? rd_ptr[ADDR_W-1:0] : '0;

    always_comb begin
        n_state    = r_state;
        n_init_cnt = r_init_cnt;
        n_free     = r_free;
        n_top      = r_top;
        n_op       = r_op;
        n_sid      = r_sid;
        n_val      = r_val;
        n_exists   = r_exists;
        n_top_sel  = r_top_sel;
        n_strobe   = 1'b0;
        n_out      = r_out;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        data_we    = 1'b0;
        data_waddr = '0;
        data_wdata = r_val;

        unique case (r_state)
            S_INIT: begin
                // chain slot i to slot i+1; the last slot lands on null
                link_we    = 1'b1;
                link_waddr = r_init_cnt[ADDR_W-1:0];
                link_wdata = r_init_cnt + t_ptr'(1);
                n_init_cnt = r_init_cnt + t_ptr'(1);
                if (r_init_cnt == t_ptr'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op      = i_in.operation;
                    n_sid     = i_in.stack_id;
                    n_val     = i_in.push_value;
                    n_exists  = exists;
                    n_top_sel = top_sel;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out.popped_value = '0;
                n_out.status       = ST_OK;
                if (r_op == OP_PUSH) begin
                    if (r_exists && !ptr_ok(r_free)) begin
                        n_out.status = ST_FULL;
                    end else if (r_exists) begin
                        // link the free head on top of the stack, advance free head
                        link_we    = 1'b1;
                        link_waddr = r_free[ADDR_W-1:0];
                        link_wdata = r_top_sel;
                        data_we    = 1'b1;
                        data_waddr = r_free[ADDR_W-1:0];
                        n_free     = link_rdata;
                        for (int s = 0; s < STACKS; s++) begin
                            if (int'(r_sid) == s) begin
                                n_top[s] = r_free;
                            end
                        end
                    end
                end else begin
                    if (!ptr_ok(r_top_sel)) begin
                        n_out.status       = ST_EMPTY;
                        n_out.popped_value = EMPTY_POP_VALUE;
                    end else begin
                        // unlink the top slot and return it to the free list
                        n_out.popped_value = data_rdata;
                        link_we    = 1'b1;
                        link_waddr = r_top_sel[ADDR_W-1:0];
                        link_wdata = r_free;
                        n_free     = r_top_sel;
                        for (int s = 0; s < STACKS; s++) begin
                            if (int'(r_sid) == s) begin
                                n_top[s] = link_rdata;
                            end
                        end
                    end
                end
                n_out.store_full = !ptr_ok(n_free);
                n_out.empty_mask = '0;
                for (int s = 0; s < MASK_N; s++) begin
                    n_out.empty_mask[s] = !ptr_ok(n_top[s]);
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_cnt <= '0;
            r_free     <= '0;
            for (int s = 0; s < STACKS; s++) begin
                r_top[s] <= LINK_NULL;
            end
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_free     <= n_free;
            r_top      <= n_top;
            r_strobe   <= n_strobe;
        end
        // payload: no reset
        r_op      <= n_op;
        r_sid     <= n_sid;
        r_val     <= n_val;
        r_exists  <= n_exists;
        r_top_sel <= n_top_sel;
        r_out     <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    `MSFL_ASSERT_NEXT(a_accept_exec, start && !busy, r_state == S_EXEC, "accept did not enter execute")
    `MSFL_ASSERT_NEXT(a_exec_strobe, r_state == S_EXEC, o_strobe && !busy, "execute gave no result")
    `MSFL_ASSERT_SAME(a_full_flag, o_strobe && o_out.status == ST_FULL, o_out.store_full, "refused push without store_full")
    `MSFL_ASSERT_SAME(a_empty_val, o_strobe && o_out.status == ST_EMPTY, o_out.popped_value == EMPTY_POP_VALUE, "empty pop value wrong")
    `MSFL_ASSERT_SAME(a_strobe_idle, o_strobe, r_state == S_IDLE, "result outside idle")

endmodule
